@@ src/mfde_pkg.sv @@
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and constants of the monochrome frame buffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

   localparam int SCREEN_WIDTH = 128;
   localparam int PAGE_COUNT   = 8;
   localparam int SCREEN_ROWS  = PAGE_COUNT * 8;
   localparam int STORE_DEPTH  = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int SLOPE_SCALE  = 10;

   // Slope k = dy * 10 / dx needs this many quotient bits.
   localparam int K_W          = $clog2(SCREEN_ROWS * SLOPE_SCALE + 1);
   // k / 10 by reciprocal multiplication, exact for k below 2^K_W.
   localparam int RECIP        = 6554;
   localparam int RECIP_SHIFT  = 16;
   localparam int KP_W         = K_W + 13;
   localparam int Q_W          = 9;
   localparam int COORD_W      = 11;

   localparam int FIFO_DEPTH   = 2;
   localparam int FIFO_PTR_W   = 1;
   localparam int FIFO_CNT_W   = 2;

   // Request kinds as they arrive on the input channel.
   localparam logic [2:0] KIND_CLEAR  = 3'd0;
   localparam logic [2:0] KIND_SET    = 3'd1;
   localparam logic [2:0] KIND_UNSET  = 3'd2;
   localparam logic [2:0] KIND_LINE   = 3'd3;
   localparam logic [2:0] KIND_CIRCLE = 3'd4;
   localparam logic [2:0] KIND_READ   = 3'd5;

   // Operations after classification.
   localparam logic [2:0] OP_NOP    = 3'd0;
   localparam logic [2:0] OP_CLEAR  = 3'd1;
   localparam logic [2:0] OP_SET    = 3'd2;
   localparam logic [2:0] OP_UNSET  = 3'd3;
   localparam logic [2:0] OP_LINE   = 3'd4;
   localparam logic [2:0] OP_CIRCLE = 3'd5;
   localparam logic [2:0] OP_READ   = 3'd6;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] x1;
      logic [7:0] y1;
      logic [7:0] dx;
      logic [7:0] dy;
      logic [7:0] radius;
      logic       vertical;
      logic       status;
   } cmd_type;

endpackage

@@ src/mfde_front.sv @@
// ----------------------------------------------------------------------------
// mfde_front
// Classifies an incoming request: checks line arguments and read range.
// ----------------------------------------------------------------------------
module mfde_front import mfde_pkg::*; (
   input  logic [2:0] kind,
   input  logic [7:0] first_x,
   input  logic [7:0] first_y,
   input  logic [7:0] second_x,
   input  logic [7:0] second_y,
   input  logic [7:0] radius,
   output cmd_type    cmd
);

   logic line_bad;
   logic read_ok;

   assign line_bad = (int'(second_x) > SCREEN_WIDTH) || (int'(second_y) > SCREEN_ROWS) ||
                     (first_x > second_x) || (first_y > second_y);
   assign read_ok  = (int'(first_x) < SCREEN_WIDTH) && (int'(first_y) < PAGE_COUNT);

   always_comb begin
      cmd          = '0;
      cmd.x1       = first_x;
      cmd.y1       = first_y;
      cmd.dx       = second_x - first_x;
      cmd.dy       = second_y - first_y;
      cmd.radius   = radius;
      cmd.vertical = (first_x == second_x);
      unique case (kind)
         KIND_CLEAR:  cmd.op = OP_CLEAR;
         KIND_SET:    cmd.op = OP_SET;
         KIND_UNSET:  cmd.op = OP_UNSET;
         KIND_LINE: begin
            // A rejected line draws nothing and reports it in the status.
            cmd.op     = line_bad ? OP_NOP : OP_LINE;
            cmd.status = line_bad;
         end
         KIND_CIRCLE: cmd.op = OP_CIRCLE;
         KIND_READ:   cmd.op = read_ok ? OP_READ : OP_NOP;
         default:     cmd.op = OP_NOP;
      endcase
   end

endmodule

@@ src/mfde_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// mfde_cmd_fifo
// Short command queue between the classifier and the drawing back end.
// ----------------------------------------------------------------------------
module mfde_cmd_fifo import mfde_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wptr_ff, wptr_in;
   logic [FIFO_PTR_W-1:0]  rptr_ff, rptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wptr_ff] <= push_data;
   end

endmodule

@@ src/mfde_back.sv @@
// ----------------------------------------------------------------------------
// mfde_back
// Drawing back end: frame store, clear sweep, pixel read-modify-write,
// line stepping with a serial slope divider, and the circle walk.
// ----------------------------------------------------------------------------
module mfde_back import mfde_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       fifo_empty,
   output logic       fifo_pop,
   output logic       init_busy,
   output logic       res_valid,
   output logic [7:0] res_data,
   output logic       res_status,
   input  logic       res_pop
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_CLEAR    = 5'd1;
   localparam logic [4:0] S_PIX      = 5'd2;
   localparam logic [4:0] S_RD       = 5'd3;
   localparam logic [4:0] S_RD_WAIT  = 5'd4;
   localparam logic [4:0] S_PX_WR    = 5'd5;
   localparam logic [4:0] S_DONE     = 5'd6;
   localparam logic [4:0] S_DIV      = 5'd7;
   localparam logic [4:0] S_KSPLIT   = 5'd8;
   localparam logic [4:0] S_LINE     = 5'd9;
   localparam logic [4:0] S_CIR_RR   = 5'd10;
   localparam logic [4:0] S_CIR_B2   = 5'd11;
   localparam logic [4:0] S_CIR_TEST = 5'd12;
   localparam logic [4:0] S_CIR_PLOT = 5'd13;
   localparam logic [4:0] S_CIR_STEP = 5'd14;
   localparam logic [4:0] S_CIR_A2   = 5'd15;
   localparam logic [4:0] S_CIR_CMP  = 5'd16;

   localparam int DCNT_W = $clog2(K_W + 1);

   function automatic logic [ADDR_W-1:0] addr_of(input logic [7:0] col,
                                                 input logic [7:0] page);
      addr_of = ADDR_W'(int'(col) * PAGE_COUNT + int'(page));
   endfunction

   logic [7:0] mem [STORE_DEPTH];
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;
   logic [7:0]        rd_data_ff;

   logic [4:0]        state_ff, state_in;
   logic              init_ff, init_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   cmd_type           cmd_ff, cmd_in;
   logic              lit_ff, lit_in;
   logic [4:0]        ret_ff, ret_in;
   logic [ADDR_W-1:0] pix_addr_ff, pix_addr_in;
   logic [7:0]        pix_mask_ff, pix_mask_in;
   logic [K_W-1:0]    num_ff, num_in;
   logic [K_W-1:0]    quo_ff, quo_in;
   logic [7:0]        drem_ff, drem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [Q_W-1:0]    kq_ff, kq_in;
   logic [3:0]        kr_ff, kr_in;
   logic [7:0]        i_ff, i_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [3:0]        acc_ff, acc_in;
   logic [2:0]        pt_ff, pt_in;
   logic [8:0]        a_ff, a_in;
   logic [7:0]        b_ff, b_in;
   logic [15:0]       rr_ff, rr_in;
   logic [15:0]       bb_ff, bb_in;
   logic [17:0]       a2_ff, a2_in;
   logic              res_valid_ff, res_valid_in;
   logic [7:0]        res_data_ff, res_data_in;
   logic              res_status_ff, res_status_in;

   // Pixel request shared by the drawing states.
   logic                      pix_req;
   logic [COORD_W-1:0]        pix_x, pix_y;
   logic [4:0]                pix_next;
   logic                      pix_vis;

   logic [8:0]                trial;
   logic [KP_W-1:0]           kprod;
   logic [Q_W-1:0]            kq_calc;
   logic [K_W-1:0]            kr_full;
   logic [4:0]                acc_sum;
   logic [7:0]                line_n;
   logic [COORD_W-1:0]        cx, cy, ea, eb;

   assign init_busy  = init_ff;
   assign res_valid  = res_valid_ff;
   assign res_data   = res_data_ff;
   assign res_status = res_status_ff;

   assign trial   = {drem_ff, num_ff[K_W-1]};
   assign kprod   = KP_W'(quo_ff) * KP_W'(RECIP);
   assign kq_calc = kprod[RECIP_SHIFT +: Q_W];
   assign kr_full = quo_ff - K_W'(kq_calc) * K_W'(SLOPE_SCALE);
   assign acc_sum = {1'b0, acc_ff} + {1'b0, kr_ff};
   assign line_n  = cmd_ff.vertical ? cmd_ff.dy : cmd_ff.dx;
   assign cx      = COORD_W'(cmd_ff.x1);
   assign cy      = COORD_W'(cmd_ff.y1);
   assign ea      = COORD_W'(a_ff);
   assign eb      = COORD_W'(b_ff);
   assign pix_vis = !pix_x[COORD_W-1] && !pix_y[COORD_W-1] &&
                    (pix_x[COORD_W-2:0] < (COORD_W-1)'(SCREEN_WIDTH)) &&
                    (pix_y[COORD_W-2:0] < (COORD_W-1)'(SCREEN_ROWS));

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      lit_in        = lit_ff;
      ret_in        = ret_ff;
      pix_addr_in   = pix_addr_ff;
      pix_mask_in   = pix_mask_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      drem_in       = drem_ff;
      dcnt_in       = dcnt_ff;
      kq_in         = kq_ff;
      kr_in         = kr_ff;
      i_in          = i_ff;
      q_in          = q_ff;
      acc_in        = acc_ff;
      pt_in         = pt_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      rr_in         = rr_ff;
      bb_in         = bb_ff;
      a2_in         = a2_ff;
      res_valid_in  = res_valid_ff && !res_pop;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      fifo_pop      = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = pix_addr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = addr_of(cmd_ff.x1, cmd_ff.y1);
      pix_req       = 1'b0;
      pix_x         = cx;
      pix_y         = cy;
      pix_next      = S_DONE;

      unique case (state_ff)
         S_IDLE: begin
            if (!fifo_empty && !res_valid_ff) begin
               fifo_pop = 1'b1;
               cmd_in   = head;
               lit_in   = (head.op != OP_UNSET);
               cnt_in   = '0;
               i_in     = '0;
               q_in     = '0;
               acc_in   = '0;
               pt_in    = '0;
               a_in     = '0;
               b_in     = head.radius;
               num_in   = K_W'(head.dy) * K_W'(SLOPE_SCALE);
               quo_in   = '0;
               drem_in  = '0;
               dcnt_in  = '0;
               kq_in    = Q_W'(1);
               kr_in    = '0;
               unique case (head.op)
                  OP_CLEAR:            state_in = S_CLEAR;
                  OP_SET, OP_UNSET:    state_in = S_PIX;
                  OP_LINE:             state_in = head.vertical ? S_LINE : S_DIV;
                  OP_CIRCLE:           state_in = S_CIR_RR;
                  OP_READ:             state_in = S_RD;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_DONE;
            end
         end
         S_PIX: begin
            pix_req  = 1'b1;
            pix_next = S_DONE;
         end
         S_RD: begin
            mem_re   = 1'b1;
            state_in = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            res_valid_in  = 1'b1;
            res_data_in   = rd_data_ff;
            res_status_in = 1'b0;
            state_in      = S_IDLE;
         end
         S_PX_WR: begin
            mem_we    = 1'b1;
            mem_wdata = lit_ff ? (rd_data_ff | pix_mask_ff) : (rd_data_ff & ~pix_mask_ff);
            state_in  = ret_ff;
         end
         S_DONE: begin
            res_valid_in  = 1'b1;
            res_data_in   = '0;
            res_status_in = cmd_ff.status;
            state_in      = S_IDLE;
         end
         S_DIV: begin
            // One quotient bit a cycle of dy * 10 / dx.
            if (trial >= {1'b0, cmd_ff.dx}) begin
               drem_in = 8'(trial - {1'b0, cmd_ff.dx});
               quo_in  = {quo_ff[K_W-2:0], 1'b1};
            end else begin
               drem_in = trial[7:0];
               quo_in  = {quo_ff[K_W-2:0], 1'b0};
            end
            num_in  = {num_ff[K_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(K_W - 1)) state_in = S_KSPLIT;
         end
         S_KSPLIT: begin
            kq_in    = kq_calc;
            kr_in    = kr_full[3:0];
            state_in = S_LINE;
         end
         S_LINE: begin
            // The row offset i*k/10 is tracked as a quotient and remainder that grow by
            // k/10 and k%10 each step; a vertical line grows it by one row per step.
            if (i_ff == line_n) begin
               state_in = S_DONE;
            end else begin
               pix_req  = 1'b1;
               pix_next = S_LINE;
               pix_x    = cx + (cmd_ff.vertical ? '0 : COORD_W'(i_ff));
               pix_y    = cy + COORD_W'(q_ff);
               i_in     = i_ff + 1'b1;
               if (acc_sum >= 5'(SLOPE_SCALE)) begin
                  acc_in = 4'(acc_sum - 5'(SLOPE_SCALE));
                  q_in   = q_ff + kq_ff + 1'b1;
               end else begin
                  acc_in = acc_sum[3:0];
                  q_in   = q_ff + kq_ff;
               end
            end
         end
         S_CIR_RR: begin
            rr_in    = cmd_ff.radius * cmd_ff.radius;
            state_in = S_CIR_B2;
         end
         S_CIR_B2: begin
            bb_in    = b_ff * b_ff;
            state_in = S_CIR_TEST;
         end
         S_CIR_TEST: begin
            state_in = ({1'b0, bb_ff, 1'b0} >= {2'b0, rr_ff}) ? S_CIR_PLOT : S_DONE;
         end
         S_CIR_PLOT: begin
            pix_req  = 1'b1;
            pix_next = (pt_ff == 3'd7) ? S_CIR_STEP : S_CIR_PLOT;
            pt_in    = pt_ff + 1'b1;
            unique case (pt_ff)
               3'd0: begin pix_x = cx + ea; pix_y = cy - eb; end
               3'd1: begin pix_x = cx - ea; pix_y = cy - eb; end
               3'd2: begin pix_x = cx - ea; pix_y = cy + eb; end
               3'd3: begin pix_x = cx + ea; pix_y = cy + eb; end
               3'd4: begin pix_x = cx + eb; pix_y = cy + ea; end
               3'd5: begin pix_x = cx + eb; pix_y = cy - ea; end
               3'd6: begin pix_x = cx - eb; pix_y = cy - ea; end
               default: begin pix_x = cx - eb; pix_y = cy + ea; end
            endcase
         end
         S_CIR_STEP: begin
            // A zero radius plots only the centre.
            if (cmd_ff.radius == '0) begin
               state_in = S_DONE;
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = S_CIR_A2;
            end
         end
         S_CIR_A2: begin
            a2_in    = a_ff * a_ff;
            state_in = S_CIR_CMP;
         end
         S_CIR_CMP: begin
            if ((19'(a2_ff) + 19'(bb_ff)) > 19'(rr_ff)) begin
               a_in     = a_ff - 1'b1;
               b_in     = b_ff - 1'b1;
               state_in = S_CIR_B2;
            end else begin
               state_in = S_CIR_TEST;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (pix_req) begin
         if (pix_vis) begin
            mem_re      = 1'b1;
            mem_raddr   = addr_of(pix_x[7:0], {3'b0, pix_y[7:3]});
            pix_addr_in = mem_raddr;
            pix_mask_in = 8'(1) << pix_y[2:0];
            ret_in      = pix_next;
            state_in    = S_PX_WR;
         end else begin
            state_in = pix_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         init_ff      <= 1'b1;
         cnt_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         cnt_ff       <= cnt_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      lit_ff        <= lit_in;
      ret_ff        <= ret_in;
      pix_addr_ff   <= pix_addr_in;
      pix_mask_ff   <= pix_mask_in;
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      drem_ff       <= drem_in;
      dcnt_ff       <= dcnt_in;
      kq_ff         <= kq_in;
      kr_ff         <= kr_in;
      i_ff          <= i_in;
      q_ff          <= q_in;
      acc_ff        <= acc_in;
      pt_ff         <= pt_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      rr_ff         <= rr_in;
      bb_ff         <= bb_in;
      a2_ff         <= a2_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

endmodule

@@ src/mono_framebuffer_draw_engine.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Page-organized monochrome frame store with pixel, line and circle drawing.
// ----------------------------------------------------------------------------
// Requests enter through a queue-like port: a transfer happens when req_push
// is high and req_full is low. Each request gives exactly one response, shown
// while rsp_empty is low and taken when rsp_pop is high.
// A classifier checks line arguments and read range on entry, and a two-entry
// command queue feeds the drawing engine, so requests keep arriving while the
// engine works or while a response waits.
// Every visible pixel update is a read-modify-write of its store byte, read
// and written through separate store ports; the clear sweep only writes. A
// line first runs the serial slope divider unless it is vertical, and a
// circle is drawn along the steps of its walk.
// After reset the engine sweeps zeros through all 1024 store bytes, holding
// req_full high until the sweep ends. When the response side stalls, the
// engine holds its finished response and starts nothing new, and the command
// queue fills until req_full rises.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine import mfde_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_first_x,
   input  logic [7:0] req_first_y,
   input  logic [7:0] req_second_x,
   input  logic [7:0] req_second_y,
   input  logic [7:0] req_radius,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_read_data,
   output logic       rsp_status
);

   cmd_type front_cmd;
   cmd_type head;
   logic    fifo_full, fifo_empty, fifo_pop;
   logic    init_busy;
   logic    res_valid;

   assign req_full  = fifo_full || init_busy;
   assign rsp_empty = !res_valid;

   mfde_front u_front (
      .kind     (req_kind),
      .first_x  (req_first_x),
      .first_y  (req_first_y),
      .second_x (req_second_x),
      .second_y (req_second_y),
      .radius   (req_radius),
      .cmd      (front_cmd)
   );

   mfde_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !init_busy),
      .push_data (front_cmd),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .head      (head),
      .empty     (fifo_empty)
   );

   mfde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .fifo_empty (fifo_empty),
      .fifo_pop   (fifo_pop),
      .init_busy  (init_busy),
      .res_valid  (res_valid),
      .res_data   (rsp_read_data),
      .res_status (rsp_status),
      .res_pop    (rsp_pop)
   );

endmodule
